### rtl/psw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_pkg
// shared widths, defaults and types of the priority schedule wait-times unit
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int ID_W          = 16;
    localparam int PRIO_W        = 8;
    localparam int BURST_W       = 16;
    localparam int RES_W         = 20;
    localparam int MAX_JOBS_DEF  = 16;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 120;

    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id;
    } job_rec_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### rtl/psw_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module psw_divider #(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output psw_pkg::div_status_t  status
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### rtl/priority_schedule_wait_times_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_schedule_wait_times_unit
// non-preemptive priority scheduler with waiting and turnaround times
// ----------------------------------------------------------------------------
// Jobs arrive on the s_ channel, one transaction per job, and are stored at
// one per cycle. Jobs beyond MAX_JOBS are dropped. The transaction with tlast
// closes the batch: s_tready then stays low while a small sequencer orders
// the stored jobs by selection over a job memory with one read and one write
// port (one compare per cycle), sums the waiting times and the bursts, and
// runs two divisions through one shared bit-serial divider with
// 16 + 2*clog2(MAX_JOBS+1) quotient bits. Results then leave on the m_ channel
// in schedule order, one transaction per job, with tlast on the final one.
// In a 16-job batch the selection scan takes the largest share of the time.
// A stalled m_ receiver holds the result register and the sequencer waits.
// s_tready rises again once the final result is in the output register.
// Reset empties the batch and the output register; stored jobs are not
// cleared, since only written entries are read.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times_unit #(
    parameter int MAX_JOBS = psw_pkg::MAX_JOBS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // job_id, job_priority, job_burst
    input  logic [psw_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_job_id, out_priority, out_burst, wait_ticks, turnaround_time,
    // avg_waiting, avg_turnaround
    output logic [psw_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int IDX_W  = $clog2(MAX_JOBS);
    localparam int WAIT_W = psw_pkg::BURST_W + CNT_W;
    localparam int SUM_W  = psw_pkg::BURST_W + 2 * CNT_W;

    typedef enum logic [3:0] {
        LOAD,
        SORT_INIT,
        SORT_FIRST,
        SORT_SCAN,
        SWAP_A,
        SWAP_B,
        TOT_START,
        TOT_ACC,
        DIV_WT,
        DIV_WT_WAIT,
        DIV_TAT,
        DIV_TAT_WAIT,
        EMIT_RD,
        EMIT_WR
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              n_reg, n_next;
    logic [IDX_W-1:0]              i_reg, i_next;
    logic [IDX_W-1:0]              j_reg, j_next;
    logic [IDX_W-1:0]              sel_reg, sel_next;
    logic [IDX_W-1:0]              k_reg, k_next;
    psw_pkg::job_rec_t             rec_i_reg, rec_i_next;
    psw_pkg::job_rec_t             sel_rec_reg, sel_rec_next;
    logic [WAIT_W-1:0]             wait_reg, wait_next;
    logic [SUM_W-1:0]              total_reg, total_next;
    logic [psw_pkg::RES_W-1:0]     avg_wt_reg, avg_wt_next;
    logic [psw_pkg::RES_W-1:0]     avg_tat_reg, avg_tat_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          m_tlast_reg, m_tlast_next;
    logic [psw_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    psw_pkg::job_rec_t             mem [MAX_JOBS];
    psw_pkg::job_rec_t             rd_data_reg;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    psw_pkg::job_rec_t             wr_data;

    logic                          div_start;
    logic [SUM_W-1:0]              div_quo;
    psw_pkg::div_status_t          div_stat;

    logic [IDX_W-1:0]              last_idx;
    logic [WAIT_W-1:0]             burst_ext;
    logic [WAIT_W-1:0]             tat_val;
    psw_pkg::job_rec_t             in_rec;
    logic                          in_accept;
    logic                          has_room;

    assign last_idx  = IDX_W'(n_reg - CNT_W'(1));
    assign burst_ext = WAIT_W'(rd_data_reg.burst);
    assign tat_val   = wait_reg + burst_ext;
    assign in_rec    = s_tdata[psw_pkg::IN_DATA_W-1:0];
    assign in_accept = s_tvalid && s_tready;
    assign has_room  = (count_reg < CNT_W'(MAX_JOBS));
    assign s_tready  = (state_reg == LOAD);

    psw_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (n_reg),
        .quotient (div_quo),
        .status   (div_stat)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        sel_next      = sel_reg;
        k_next        = k_reg;
        rec_i_next    = rec_i_reg;
        sel_rec_next  = sel_rec_reg;
        wait_next     = wait_reg;
        total_next    = total_reg;
        avg_wt_next   = avg_wt_reg;
        avg_tat_next  = avg_tat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tlast_next  = m_tlast_reg;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = in_rec;
        div_start     = 1'b0;

        case (state_reg)
            LOAD:
            begin
                if (in_accept)
                begin
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = IDX_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        n_next     = has_room ? count_reg + CNT_W'(1) : count_reg;
                        count_next = '0;
                        i_next     = '0;
                        state_next = SORT_INIT;
                    end
                end
            end
            SORT_INIT:
            begin
                if (i_reg == last_idx)
                begin
                    state_next = TOT_START;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg;
                    state_next = SORT_FIRST;
                end
            end
            SORT_FIRST:
            begin
                rec_i_next   = rd_data_reg;
                sel_rec_next = rd_data_reg;
                sel_next     = i_reg;
                j_next       = i_reg + IDX_W'(1);
                rd_en        = 1'b1;
                rd_addr      = i_reg + IDX_W'(1);
                state_next   = SORT_SCAN;
            end
            SORT_SCAN:
            begin
                if (rd_data_reg.prio < sel_rec_reg.prio)
                begin
                    sel_rec_next = rd_data_reg;
                    sel_next     = j_reg;
                end
                if (j_reg == last_idx)
                begin
                    state_next = SWAP_A;
                end
                else
                begin
                    j_next  = j_reg + IDX_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = j_reg + IDX_W'(1);
                end
            end
            SWAP_A:
            begin
                if (sel_reg == i_reg)
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = SORT_INIT;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = i_reg;
                    wr_data    = sel_rec_reg;
                    state_next = SWAP_B;
                end
            end
            SWAP_B:
            begin
                wr_en      = 1'b1;
                wr_addr    = sel_reg;
                wr_data    = rec_i_reg;
                i_next     = i_reg + IDX_W'(1);
                state_next = SORT_INIT;
            end
            TOT_START:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                k_next     = '0;
                wait_next  = '0;
                total_next = '0;
                state_next = TOT_ACC;
            end
            TOT_ACC:
            begin
                total_next = total_reg + SUM_W'(wait_reg);
                wait_next  = tat_val;
                if (k_reg == last_idx)
                begin
                    state_next = DIV_WT;
                end
                else
                begin
                    k_next  = k_reg + IDX_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = k_reg + IDX_W'(1);
                end
            end
            DIV_WT:
            begin
                div_start  = 1'b1;
                state_next = DIV_WT_WAIT;
            end
            DIV_WT_WAIT:
            begin
                if (div_stat.done)
                begin
                    avg_wt_next = psw_pkg::RES_W'(div_quo);
                    total_next  = total_reg + SUM_W'(wait_reg);
                    state_next  = DIV_TAT;
                end
            end
            DIV_TAT:
            begin
                div_start  = 1'b1;
                state_next = DIV_TAT_WAIT;
            end
            DIV_TAT_WAIT:
            begin
                if (div_stat.done)
                begin
                    avg_tat_next = psw_pkg::RES_W'(div_quo);
                    k_next       = '0;
                    wait_next    = '0;
                    state_next   = EMIT_RD;
                end
            end
            EMIT_RD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = k_reg;
                    state_next = EMIT_WR;
                end
            end
            EMIT_WR:
            begin
                m_tvalid_next = 1'b1;
                m_tlast_next  = (k_reg == last_idx);
                m_tdata_next  = {avg_tat_reg, avg_wt_reg,
                                 psw_pkg::RES_W'(tat_val), psw_pkg::RES_W'(wait_reg),
                                 rd_data_reg.burst, rd_data_reg.prio, rd_data_reg.id};
                wait_next     = tat_val;
                if (k_reg == last_idx)
                begin
                    state_next = LOAD;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = EMIT_RD;
                end
            end
            default:
            begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= LOAD;
            count_reg    <= '0;
            n_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            sel_reg      <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            n_reg        <= n_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            sel_reg      <= sel_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_i_reg   <= rec_i_next;
        sel_rec_reg <= sel_rec_next;
        wait_reg    <= wait_next;
        total_reg   <= total_next;
        avg_wt_reg  <= avg_wt_next;
        avg_tat_reg <= avg_tat_next;
    end

    // job memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_JOBS))
        else $error("job count beyond capacity");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SORT_SCAN) |-> (sel_reg >= i_reg && j_reg > i_reg && j_reg <= last_idx))
        else $error("selection scan indexes out of order");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == DIV_WT_WAIT || state_reg == DIV_TAT_WAIT))
        else $error("divider finished outside a division wait");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == EMIT_WR))
        else $error("result transaction not from emit step");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != LOAD) |-> !in_accept)
        else $error("job accepted while scheduling");

endmodule
